// ===== design/mixed_fraction_mul_div_unit_defines.svh =====
// Assertion macros shared by the unit
`ifndef MIXED_FRACTION_MUL_DIV_UNIT_DEFINES_SVH
`define MIXED_FRACTION_MUL_DIV_UNIT_DEFINES_SVH

// same-cycle implication
`define MFMD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication
`define MFMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== design/mfmd_pkg.sv =====
package mfmd_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IMPROPER,
    S_PRODUCT,
    S_WHOLE,
    S_WHOLE_WAIT,
    S_EUC,
    S_EUC_WAIT,
    S_RED_NUM,
    S_RED_NUM_WAIT,
    S_RED_DEN,
    S_RED_DEN_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_WHOLE,
    OP_EUCLID,
    OP_RED_NUM,
    OP_RED_DEN
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    improper;
    logic    product;
    logic    div_start;
    logic    div_capture;
    div_op_t op;
    logic    done;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_rem_zero;
  } status_t;

endpackage

// ===== design/mixed_fraction_mul_div_unit.sv =====
// A transaction forms the improper fractions and their product, then divides for the
//   whole part; when the remainder is nonzero it runs Euclid steps and two reductions.
// All divisions share the one bit-serial divider, so the unit takes one transaction
//   at a time; the next start is accepted the cycle after done.
// The result strobe done lasts one cycle; the receiver cannot stall.
// Synchronous active-high rst returns the controller to idle; no transaction is kept.
module mixed_fraction_mul_div_unit #(
  parameter int COMPONENT_WIDTH = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode,
  input  logic signed [COMPONENT_WIDTH-1:0]    a_integer,
  input  logic signed [COMPONENT_WIDTH-1:0]    a_numerator,
  input  logic        [COMPONENT_WIDTH-2:0]    a_denominator,
  input  logic signed [COMPONENT_WIDTH-1:0]    b_integer,
  input  logic signed [COMPONENT_WIDTH-1:0]    b_numerator,
  input  logic        [COMPONENT_WIDTH-2:0]    b_denominator,
  output logic                                 done,
  output logic signed [4*COMPONENT_WIDTH-2:0]  result_integer,
  output logic signed [3*COMPONENT_WIDTH-1:0]  result_numerator,
  output logic signed [3*COMPONENT_WIDTH-1:0]  result_denominator
);
  import mfmd_pkg::*;
  `include "mixed_fraction_mul_div_unit_defines.svh"

  cmd_t    cmd;
  status_t status;

  mfmd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mfmd_dp #(.CW(COMPONENT_WIDTH)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .mode               (mode),
    .a_integer          (a_integer),
    .a_numerator        (a_numerator),
    .a_denominator      (a_denominator),
    .b_integer          (b_integer),
    .b_numerator        (b_numerator),
    .b_denominator      (b_denominator),
    .result_integer     (result_integer),
    .result_numerator   (result_numerator),
    .result_denominator (result_denominator)
  );

  assign done = cmd.done;

  `MFMD_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `MFMD_ASSERT_NEXT(a_done_pulse, done, !done && !busy)
  `MFMD_ASSERT_IMP(a_done_in_txn, done, busy)
  `MFMD_ASSERT_IMP(a_no_overlap, cmd.div_start, !status.div_done)

endmodule

// ===== design/mfmd_div.sv =====
module mfmd_div #(
  parameter int NW = 48,
  parameter int DW = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic signed [DW-1:0] divisor,
  output logic                 done,
  output logic signed [NW-1:0] quotient,
  output logic signed [DW-1:0] remainder
);
  localparam int CNTW = $clog2(NW + 1);

  logic            running;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   quo;
  logic [DW:0]     part;
  logic [DW:0]     part_next;
  logic [DW:0]     shifted;
  logic [DW-1:0]   divmag;
  logic            qneg;
  logic            rneg;
  logic            take;

  always_comb begin
    shifted   = {part[DW-1:0], quo[NW-1]};
    take      = (shifted >= {1'b0, divmag});
    part_next = take ? (shifted - {1'b0, divmag}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo    <= dividend[NW-1] ? $unsigned(-dividend) : $unsigned(dividend);
      divmag <= divisor[DW-1] ? $unsigned(-divisor) : $unsigned(divisor);
      part   <= '0;
      qneg   <= dividend[NW-1] ^ divisor[DW-1];
      rneg   <= dividend[NW-1];
    end else if (running) begin
      part <= part_next;
      quo  <= {quo[NW-2:0], take};
    end
  end

  assign quotient  = qneg ? -$signed(quo) : $signed(quo);
  assign remainder = rneg ? -$signed(part[DW-1:0]) : $signed(part[DW-1:0]);

endmodule

// ===== design/mfmd_dp.sv =====
module mfmd_dp #(
  parameter int CW = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mfmd_pkg::cmd_t          cmd,
  output mfmd_pkg::status_t       status,
  input  logic                    mode,
  input  logic signed [CW-1:0]    a_integer,
  input  logic signed [CW-1:0]    a_numerator,
  input  logic        [CW-2:0]    a_denominator,
  input  logic signed [CW-1:0]    b_integer,
  input  logic signed [CW-1:0]    b_numerator,
  input  logic        [CW-2:0]    b_denominator,
  output logic signed [4*CW-2:0]  result_integer,
  output logic signed [3*CW-1:0]  result_numerator,
  output logic signed [3*CW-1:0]  result_denominator
);
  import mfmd_pkg::*;

  localparam int NW = 4 * CW;
  localparam int FW = 3 * CW;
  localparam int IW = 4 * CW - 1;

  logic                 mode_r;
  logic signed [CW-1:0] ai, an, bi, bn;
  logic signed [CW-1:0] ad, bd;
  logic signed [2*CW-1:0] na, nb;
  logic signed [2*CW-1:0] nb_eff, bd_eff;
  logic signed [NW-1:0] n;
  logic signed [FW-1:0] d, rem, more, less;
  logic signed [IW-1:0] whole;

  logic                 div_start, div_done;
  logic signed [NW-1:0] div_dividend, div_quo;
  logic signed [FW-1:0] div_divisor, div_rem;

  always_comb begin
    nb_eff = mode_r ? (2*CW)'(bd) : nb;
    bd_eff = mode_r ? ((nb == '0) ? (2*CW)'(1) : nb) : (2*CW)'(bd);
  end

  always_comb begin
    unique case (cmd.op)
      OP_WHOLE: begin
        div_dividend = n;
        div_divisor  = d;
      end
      OP_EUCLID: begin
        div_dividend = NW'(more);
        div_divisor  = less;
      end
      OP_RED_NUM: begin
        div_dividend = NW'(rem);
        div_divisor  = more;
      end
      default: begin
        div_dividend = NW'(d);
        div_divisor  = more;
      end
    endcase
  end

  assign div_start = cmd.div_start;

  mfmd_div #(.NW(NW), .DW(FW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign status.div_done     = div_done;
  assign status.div_rem_zero = (div_rem == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      ai     <= a_integer;
      an     <= a_numerator;
      bi     <= b_integer;
      bn     <= b_numerator;
      ad     <= (a_denominator == '0) ? CW'(1) : $signed({1'b0, a_denominator});
      bd     <= (b_denominator == '0) ? CW'(1) : $signed({1'b0, b_denominator});
    end
    if (cmd.improper) begin
      na <= (2*CW)'(an) + (2*CW)'(ai) * (2*CW)'(ad);
      nb <= (2*CW)'(bn) + (2*CW)'(bi) * (2*CW)'(bd);
    end
    if (cmd.product) begin
      n <= NW'(na) * NW'(nb_eff);
      d <= FW'(ad) * FW'(bd_eff);
    end
    if (cmd.div_capture) begin
      unique case (cmd.op)
        OP_WHOLE: begin
          whole <= div_quo[IW-1:0];
          rem   <= div_rem;
          if (div_rem > d) begin
            more <= div_rem;
            less <= d;
          end else begin
            more <= d;
            less <= div_rem;
          end
        end
        OP_EUCLID: begin
          more <= less;
          less <= div_rem;
        end
        OP_RED_NUM: rem <= div_quo[FW-1:0];
        default:    d   <= div_quo[FW-1:0];
      endcase
    end
  end

  assign result_integer     = whole;
  assign result_numerator   = rem;
  assign result_denominator = d;

endmodule

// ===== design/mfmd_ctrl.sv =====
module mfmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mfmd_pkg::status_t status,
  output mfmd_pkg::cmd_t    cmd,
  output logic              busy
);
  import mfmd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (start) state_next = S_IMPROPER;
      S_IMPROPER:   state_next = S_PRODUCT;
      S_PRODUCT:    state_next = S_WHOLE;
      S_WHOLE:      state_next = S_WHOLE_WAIT;
      S_WHOLE_WAIT: if (status.div_done) begin
        state_next = status.div_rem_zero ? S_DONE : S_EUC;
      end
      S_EUC:        state_next = S_EUC_WAIT;
      S_EUC_WAIT:   if (status.div_done) begin
        state_next = status.div_rem_zero ? S_RED_NUM : S_EUC;
      end
      S_RED_NUM:      state_next = S_RED_NUM_WAIT;
      S_RED_NUM_WAIT: if (status.div_done) state_next = S_RED_DEN;
      S_RED_DEN:      state_next = S_RED_DEN_WAIT;
      S_RED_DEN_WAIT: if (status.div_done) state_next = S_DONE;
      S_DONE:         state_next = S_IDLE;
      default:        state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:         cmd.load = start;
      S_IMPROPER:     cmd.improper = 1'b1;
      S_PRODUCT:      cmd.product = 1'b1;
      S_WHOLE: begin
        cmd.op        = OP_WHOLE;
        cmd.div_start = 1'b1;
      end
      S_WHOLE_WAIT: begin
        cmd.op          = OP_WHOLE;
        cmd.div_capture = status.div_done;
      end
      S_EUC: begin
        cmd.op        = OP_EUCLID;
        cmd.div_start = 1'b1;
      end
      S_EUC_WAIT: begin
        cmd.op          = OP_EUCLID;
        cmd.div_capture = status.div_done;
      end
      S_RED_NUM: begin
        cmd.op        = OP_RED_NUM;
        cmd.div_start = 1'b1;
      end
      S_RED_NUM_WAIT: begin
        cmd.op          = OP_RED_NUM;
        cmd.div_capture = status.div_done;
      end
      S_RED_DEN: begin
        cmd.op        = OP_RED_DEN;
        cmd.div_start = 1'b1;
      end
      S_RED_DEN_WAIT: begin
        cmd.op          = OP_RED_DEN;
        cmd.div_capture = status.div_done;
      end
      S_DONE:         cmd.done = 1'b1;
      default:        cmd = '0;
    endcase
  end

endmodule
